>>> design/fifo_replaced_key_handle_cache_top_defines.svh
// assertion macros for the key/handle cache
`ifndef FIFO_REPLACED_KEY_HANDLE_CACHE_TOP_DEFINES_SVH
`define FIFO_REPLACED_KEY_HANDLE_CACHE_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define FKHC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define FKHC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/fkhc_pkg.sv
// package: types and constants of the key/handle cache
`timescale 1ns / 1ps
package fkhc_pkg;

  localparam int ENTRIES     = 256;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int CNT_W       = $clog2(ENTRIES + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] MISS_VALUE = 32'hDEADBEEF;

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_INSERT = 1'b1;

  typedef struct packed {
    logic        action;
    logic [31:0] key;
    logic [31:0] handle;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] found_handle;
    logic        evicted_valid;
    logic [31:0] evicted_handle;
  } res_t;

  typedef struct packed {
    logic valid;
    req_t req;
  } q_head_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_INS_RD,
    ST_INS_WR
  } state_t;

endpackage

>>> design/fkhc_front.sv
// front end: accepts requests into a short queue
`timescale 1ns / 1ps
module fkhc_front
  import fkhc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  req_t    request,
  output logic    busy,
  output q_head_t head,
  input  logic    pop
);

  req_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              take;

  assign busy = (count == QCNT_W'(QUEUE_DEPTH));
  assign push = start && !busy;
  assign take = pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.req   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= request;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !take) begin
        count <= count + 1'b1;
      end else if (take && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> design/fkhc_back.sv
// back end: table memories, scan and insert sequencer, result register
`timescale 1ns / 1ps
module fkhc_back
  import fkhc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  q_head_t head,
  output logic    pop,
  output logic    done,
  output res_t    result
);

  logic [31:0]      key_mem [ENTRIES];
  logic [31:0]      hdl_mem [ENTRIES];
  logic [31:0]      key_rd;
  logic [31:0]      hdl_rd;

  state_t           state;
  state_t           state_next;
  req_t             cur;
  logic [CNT_W-1:0] issue_idx;
  logic [CNT_W-1:0] fill;
  logic [IDX_W-1:0] wp;
  logic             pend;
  logic             pend_last;

  logic             issue;
  logic             finish;
  logic             we;
  logic             full;
  logic [IDX_W-1:0] rd_addr;
  res_t             res_next;

  assign full = (fill == CNT_W'(ENTRIES));

  // memories
  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[wp] <= cur.key;
      hdl_mem[wp] <= cur.handle;
    end
    key_rd <= key_mem[rd_addr];
    hdl_rd <= hdl_mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (head.valid) begin
          state_next = (head.req.action == ACT_INSERT) ? ST_INS_RD : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (finish) begin
          state_next = ST_IDLE;
        end
      end
      ST_INS_RD: state_next = ST_INS_WR;
      ST_INS_WR: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    finish   = 1'b0;
    issue    = 1'b0;
    we       = 1'b0;
    rd_addr  = wp;
    res_next = '{hit: 1'b0, found_handle: MISS_VALUE,
                 evicted_valid: 1'b0, evicted_handle: 32'h0};
    unique case (state)
      ST_IDLE: begin
        pop = head.valid;
      end
      ST_SCAN: begin
        issue   = (issue_idx < fill);
        rd_addr = issue_idx[IDX_W-1:0];
        if (fill == '0) begin
          finish = 1'b1;
        end else if (pend && (key_rd == cur.key)) begin
          finish                = 1'b1;
          res_next.hit          = 1'b1;
          res_next.found_handle = hdl_rd;
        end else if (pend && pend_last) begin
          finish = 1'b1;
        end
      end
      ST_INS_RD: begin
      end
      ST_INS_WR: begin
        we                      = 1'b1;
        finish                  = 1'b1;
        res_next.evicted_valid  = full;
        res_next.evicted_handle = full ? hdl_rd : 32'h0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head.req;
    end
    if (finish) begin
      result <= res_next;
    end
    pend_last <= (issue_idx == fill - CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      issue_idx <= '0;
      pend      <= 1'b0;
      fill      <= '0;
      wp        <= '0;
      done      <= 1'b0;
    end else begin
      state <= state_next;
      done  <= finish;
      pend  <= (state == ST_SCAN) && issue && !finish;
      if (pop) begin
        issue_idx <= '0;
      end else if (issue) begin
        issue_idx <= issue_idx + 1'b1;
      end
      if (we) begin
        wp <= (wp == IDX_W'(ENTRIES - 1)) ? '0 : wp + 1'b1;
        if (!full) begin
          fill <= fill + 1'b1;
        end
      end
    end
  end

endmodule

>>> design/fifo_replaced_key_handle_cache_top.sv
// top level of the fifo-replaced key/handle cache
// A request (start high while busy is low) is either a lookup or an insert.
// A lookup scans the filled slots of the key memory one per cycle in index
// order and returns the first match's handle.
// An insert reads the slot being replaced, then writes it. Slots are
// replaced round-robin; once the table is full, the insert reports the
// replaced handle in evicted_handle. Every result shows for a single cycle
// with done high and cannot be held off by the receiver.
// A two-entry request queue lets new requests be taken while one is in work;
// busy is high only while that queue is full.
`timescale 1ns / 1ps
`include "fifo_replaced_key_handle_cache_top_defines.svh"
module fifo_replaced_key_handle_cache_top
  import fkhc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t request,
  output logic busy,
  output logic done,
  output res_t result
);

  q_head_t head;
  logic    pop;

  fkhc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .head    (head),
    .pop     (pop)
  );

  fkhc_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .done   (done),
    .result (result)
  );

  `FKHC_ASSERT_NOW(a_hit_excl_evict, done, !(result.hit && result.evicted_valid), "hit and eviction together")
  `FKHC_ASSERT_NOW(a_miss_value, done && !result.hit, result.found_handle == MISS_VALUE, "miss without sentinel")
  `FKHC_ASSERT_NOW(a_evict_zero, done && !result.evicted_valid, result.evicted_handle == 32'h0, "stale evicted handle")
  `FKHC_ASSERT_NEXT(a_done_single, done, !done, "result strobe held two cycles")

endmodule

>>> bench/fifo_replaced_key_handle_cache_top_tb.sv
// testbench: key/handle cache lookups, inserts and evictions checked against a behavioral cache
`timescale 1ns / 1ps
module fifo_replaced_key_handle_cache_top_tb;
  import fkhc_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 300;

  logic clk = 1'b0;
  logic rst;
  logic start;
  req_t request;
  logic busy;
  logic done;
  res_t result;

  logic [31:0] cache_keys [ENTRIES];
  logic [31:0] cache_handles [ENTRIES];
  logic [IDX_W-1:0] next_slot;
  int filled_slots;

  res_t pending_responses [$];
  int mismatch_count;
  int stall_cycles;
  int sender_idle_pct;

  fifo_replaced_key_handle_cache_top u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .request(request),
    .busy(busy),
    .done(done),
    .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic res_t compute_cache_response(req_t r);
    res_t resp;
    resp.hit = 1'b0;
    resp.found_handle = MISS_VALUE;
    resp.evicted_valid = 1'b0;
    resp.evicted_handle = 32'h0;
    if (r.action == ACT_INSERT) begin
      // table full: the oldest slot is replaced and its handle reported
      if (filled_slots == ENTRIES) begin
        resp.evicted_valid = 1'b1;
        resp.evicted_handle = cache_handles[next_slot];
      end else begin
        filled_slots++;
      end
      cache_keys[next_slot] = r.key;
      cache_handles[next_slot] = r.handle;
      next_slot++;
    end else begin
      for (int i = 0; i < filled_slots; i++) begin
        if (cache_keys[IDX_W'(i)] == r.key) begin
          resp.hit = 1'b1;
          resp.found_handle = cache_handles[IDX_W'(i)];
          break;
        end
      end
    end
    return resp;
  endfunction

  function automatic req_t make_request(logic action, logic [31:0] key, logic [31:0] handle);
    req_t r;
    r.action = action;
    r.key = key;
    r.handle = handle;
    return r;
  endfunction

  function automatic logic [31:0] pick_stored_key();
    if (filled_slots == 0) begin
      return $urandom();
    end
    return cache_keys[IDX_W'($urandom_range(filled_slots - 1))];
  endfunction

  function automatic logic [31:0] newest_key();
    logic [IDX_W-1:0] slot;
    slot = next_slot - 1'b1;
    if (filled_slots == 0) begin
      return $urandom();
    end
    return cache_keys[slot];
  endfunction

  task automatic send_request(req_t r);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy !== 1'b0);
    pending_responses.push_back(compute_cache_response(r));
  endtask

  task automatic test_empty_table();
    send_request(make_request(ACT_LOOKUP, 32'h0000_0000, 32'h0000_0000));
    send_request(make_request(ACT_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
  endtask

  task automatic test_field_extremes();
    send_request(make_request(ACT_INSERT, 32'h0000_0000, 32'h0000_0000));
    send_request(make_request(ACT_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_request(make_request(ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000));
    send_request(make_request(ACT_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF));
    send_request(make_request(ACT_LOOKUP, 32'h0000_0001, 32'h0000_0000));
    send_request(make_request(ACT_LOOKUP, MISS_VALUE, 32'h0000_0000));
  endtask

  task automatic test_duplicate_keys();
    send_request(make_request(ACT_INSERT, 32'hA5A5_A5A5, 32'h1111_1111));
    send_request(make_request(ACT_INSERT, 32'hA5A5_A5A5, 32'h2222_2222));
    send_request(make_request(ACT_LOOKUP, 32'hA5A5_A5A5, 32'h0000_0000));
    // newest entry must be visible right away
    send_request(make_request(ACT_INSERT, 32'h5A5A_5A5A, MISS_VALUE));
    send_request(make_request(ACT_LOOKUP, 32'h5A5A_5A5A, 32'h0000_0000));
  endtask

  task automatic test_random_traffic(int count, int idle_pct);
    int pick;
    int key_pick;
    logic [31:0] key;
    sender_idle_pct = idle_pct;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      key_pick = $urandom_range(99);
      if (pick < 65) begin
        if (key_pick < 25) key = pick_stored_key();
        else if (key_pick < 45) key = $urandom_range(15);
        else key = $urandom();
        send_request(make_request(ACT_INSERT, key, $urandom()));
      end else begin
        if (key_pick < 45) key = pick_stored_key();
        else if (key_pick < 60) key = newest_key();
        else if (key_pick < 75) key = $urandom_range(15);
        else key = $urandom();
        send_request(make_request(ACT_LOOKUP, key, $urandom()));
      end
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst && done === 1'b1) begin
      if (pending_responses.size() == 0) begin
        $display("%0t: response with none expected, expected none, actual %h", $time, result);
        mismatch_count++;
      end else begin
        want = pending_responses.pop_front();
        if (result.hit !== want.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, want.hit, result.hit);
          mismatch_count++;
        end
        if (result.found_handle !== want.found_handle) begin
          $display("%0t: found_handle expected %h actual %h", $time,
                   want.found_handle, result.found_handle);
          mismatch_count++;
        end
        if (result.evicted_valid !== want.evicted_valid) begin
          $display("%0t: evicted_valid expected %0b actual %0b", $time,
                   want.evicted_valid, result.evicted_valid);
          mismatch_count++;
        end
        if (result.evicted_handle !== want.evicted_handle) begin
          $display("%0t: evicted_handle expected %h actual %h", $time,
                   want.evicted_handle, result.evicted_handle);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && busy === 1'b0) || done === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    request <= '0;
    next_slot = '0;
    filled_slots = 0;
    sender_idle_pct = 27;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_field_extremes();
    test_duplicate_keys();
    test_random_traffic(170, 27);
    test_random_traffic(170, 77);
    test_random_traffic(160, 0);
    start <= 1'b0;

    while (pending_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/fkhc_pkg.sv
design/fkhc_front.sv
design/fkhc_back.sv
design/fifo_replaced_key_handle_cache_top.sv
bench/fifo_replaced_key_handle_cache_top_tb.sv
